// ===== hw/rtl/wf3_pkg.sv =====
package wf3_pkg;

  localparam int DefMaxWidth = 1024;
  localparam int PixW        = 24;
  localparam int ChW         = 8;
  localparam int RowW        = 16;
  localparam int OutColW     = 10;

  // filter modes
  localparam logic [1:0] ModeImpulse   = 2'd0;
  localparam logic [1:0] ModeMean      = 2'd1;
  localparam logic [1:0] ModeSharpen   = 2'd2;
  localparam logic [1:0] ModeBilateral = 2'd3;

  // register indexes
  localparam logic [1:0] RegMode   = 2'd0;
  localparam logic [1:0] RegWidth  = 2'd1;
  localparam logic [1:0] RegHeight = 2'd2;

  typedef struct packed {
    logic [1:0]  mode;
    logic [10:0] width;
    logic [15:0] height;
  } cfg_t;

  // Q16 range weight, round(65536*exp(-k)), zero from 12 on
  function automatic logic [16:0] exp_w(input logic [3:0] idx);
    logic [16:0] r;
    case (idx)
      4'd0:    r = 17'd65536;
      4'd1:    r = 17'd24109;
      4'd2:    r = 17'd8869;
      4'd3:    r = 17'd3263;
      4'd4:    r = 17'd1200;
      4'd5:    r = 17'd442;
      4'd6:    r = 17'd162;
      4'd7:    r = 17'd60;
      4'd8:    r = 17'd22;
      4'd9:    r = 17'd8;
      4'd10:   r = 17'd3;
      4'd11:   r = 17'd1;
      default: r = 17'd0;
    endcase
    return r;
  endfunction

  // floor(d*d/1024), saturated at 12, by threshold compares
  function automatic logic [3:0] sq_div(input logic [7:0] d);
    logic [3:0] q;
    q = 4'(d >= 8'd32) + 4'(d >= 8'd46) + 4'(d >= 8'd56) + 4'(d >= 8'd64)
      + 4'(d >= 8'd72) + 4'(d >= 8'd79) + 4'(d >= 8'd85) + 4'(d >= 8'd91)
      + 4'(d >= 8'd96) + 4'(d >= 8'd102) + 4'(d >= 8'd107) + 4'(d >= 8'd111);
    return q;
  endfunction

endpackage

// ===== hw/rtl/window_filter_3x3_multimode.sv =====
// Streaming 3x3 filter for three-channel pixels in raster order. Every pixel of the
// frame comes out once, tagged with its row and column; border pixels pass unchanged
// and interior pixels are filtered in the mode chosen by the mode register (impulse
// suppression, mean, Laplacian sharpen, bilateral). Results follow a pixel once its
// neighbourhood is in, so they are not in strict raster order; run_last marks the
// last result caused by an input and frame_done the bottom-right pixel. The front
// takes a new pixel only when done with the last: it accepts it, reads the three
// columns of the line memory, updates it and hands the results to a two-entry queue,
// waiting while the queue is full. The back delivers a pass-through, impulse, mean or
// sharpen result from its calculate state and a bilateral result after 9
// weighted-sum steps and 8 quotient bits. The line memory is not cleared after
// reset. Configuration writes take effect at once and belong between frames.
module window_filter_3x3_multimode import wf3_pkg::*; #(
  parameter int MAX_WIDTH = DefMaxWidth
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [1:0]         cfg_index_i,
  input  logic [15:0]        cfg_data_i,
  input  logic               valid_i,
  output logic               ready_o,
  input  logic [ChW-1:0]     channel0_i,
  input  logic [ChW-1:0]     channel1_i,
  input  logic [ChW-1:0]     channel2_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [ChW-1:0]     out_channel0_o,
  output logic [ChW-1:0]     out_channel1_o,
  output logic [ChW-1:0]     out_channel2_o,
  output logic [RowW-1:0]    out_row_o,
  output logic [OutColW-1:0] out_col_o,
  output logic               run_last_o,
  output logic               frame_done_o
);

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int EW = 3 + RowW + CW + 9 * PixW;

  cfg_t            cfg_q;
  logic            push, full, pop, empty;
  logic [EW-1:0]   f_entry, b_entry;
  logic [PixW-1:0] res_pix;
  logic [CW-1:0]   res_col;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.mode   <= ModeMean;
      cfg_q.width  <= 11'd1024;
      cfg_q.height <= 16'd1024;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        RegMode:   cfg_q.mode   <= cfg_data_i[1:0];
        RegWidth:  cfg_q.width  <= cfg_data_i[10:0];
        RegHeight: cfg_q.height <= cfg_data_i;
        default: ;
      endcase
    end
  end

  wf3_front #(.MAX_WIDTH(MAX_WIDTH), .CW(CW), .EW(EW)) u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cfg_i   (cfg_q),
    .valid_i (valid_i),
    .ready_o (ready_o),
    .pix_i   ({channel2_i, channel1_i, channel0_i}),
    .push_o  (push),
    .entry_o (f_entry),
    .full_i  (full)
  );

  wf3_fifo #(.EW(EW)) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (f_entry),
    .full_o  (full),
    .pop_i   (pop),
    .empty_o (empty),
    .data_o  (b_entry)
  );

  wf3_back #(.MAX_WIDTH(MAX_WIDTH), .CW(CW), .EW(EW)) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .mode_i      (cfg_q.mode),
    .empty_i     (empty),
    .pop_o       (pop),
    .entry_i     (b_entry),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .pix_o       (res_pix),
    .row_o       (out_row_o),
    .col_o       (res_col),
    .last_o      (run_last_o),
    .done_o      (frame_done_o)
  );

  assign out_channel0_o = res_pix[0*ChW +: ChW];
  assign out_channel1_o = res_pix[1*ChW +: ChW];
  assign out_channel2_o = res_pix[2*ChW +: ChW];
  assign out_col_o      = OutColW'(res_col);

endmodule

// ===== hw/rtl/wf3_fifo.sv =====
module wf3_fifo import wf3_pkg::*; #(
  parameter int EW = 8
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  logic [EW-1:0] data_i,
  output logic          full_o,
  input  logic          pop_i,
  output logic          empty_o,
  output logic [EW-1:0] data_o
);

  logic [EW-1:0] mem_q [2];
  logic          wp_q, rp_q;
  logic [1:0]    cnt_q;

  assign full_o  = (cnt_q == 2'd2);
  assign empty_o = (cnt_q == 2'd0);
  assign data_o  = mem_q[rp_q];

  // storage
  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wp_q] <= data_i;
  end

  // pointers and fill
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push_i) wp_q <= ~wp_q;
      if (pop_i) rp_q <= ~rp_q;
      cnt_q <= cnt_q + 2'(push_i) - 2'(pop_i);
    end
  end

endmodule

// ===== hw/rtl/wf3_front.sv =====
module wf3_front import wf3_pkg::*; #(
  parameter int MAX_WIDTH = DefMaxWidth,
  parameter int CW        = $clog2(MAX_WIDTH),
  parameter int EW        = 3 + RowW + CW + 9 * PixW
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  cfg_t            cfg_i,
  input  logic            valid_i,
  output logic            ready_o,
  input  logic [PixW-1:0] pix_i,
  output logic            push_o,
  output logic [EW-1:0]   entry_o,
  input  logic            full_i
);

  localparam int WW = (CW + 1 > 11) ? CW + 1 : 11;

  localparam logic [1:0] F_IDLE = 2'd0;
  localparam logic [1:0] F_RD   = 2'd1;
  localparam logic [1:0] F_WR   = 2'd2;
  localparam logic [1:0] F_EM   = 2'd3;

  logic [1:0]        state_q;
  logic [1:0]        step_q;
  logic [CW-1:0]     col_q, c_q;
  logic [RowW-1:0]   row_q, r_q;
  logic [PixW-1:0]   rec0_q, rec1_q, pix_q, p0_q, p1_q;
  logic              row_end_q, filt_q;
  logic [3:0]        act_q;
  logic [2*PixW-1:0] lw_q [3];
  logic [2*PixW-1:0] line_mem [MAX_WIDTH];
  logic [2*PixW-1:0] rd_q, wd;
  logic [CW-1:0]     ra, wa;
  logic              we;
  logic [WW-1:0]     w_eff;
  logic [RowW-1:0]   h_eff;
  logic              row_end, last_row, filt, acc_in, adv;
  logic [3:0]        act;
  logic [9*PixW-1:0] win, slot_win;
  logic [RowW-1:0]   slot_row;
  logic [CW-1:0]     slot_col;
  logic              slot_last, slot_done, slot_filt;

  // effective frame size
  always_comb begin
    if (cfg_i.width == 11'd0) w_eff = WW'(1);
    else if (WW'(cfg_i.width) > WW'(MAX_WIDTH)) w_eff = WW'(MAX_WIDTH);
    else w_eff = WW'(cfg_i.width);
    h_eff = (cfg_i.height == 16'd0) ? 16'd1 : cfg_i.height;
  end

  // classify the incoming pixel
  assign row_end  = WW'(col_q) >= (w_eff - WW'(1));
  assign last_row = row_q >= (h_eff - 16'd1);
  assign filt     = (row_q >= 16'd2) && (row_q < h_eff) && (col_q >= CW'(2)) &&
                    (WW'(col_q) < w_eff);
  assign act[0]   = (row_q != '0) && (col_q != '0);
  assign act[1]   = (row_q != '0) && row_end;
  assign act[2]   = last_row && (col_q != '0);
  assign act[3]   = last_row && row_end;

  assign ready_o = (state_q == F_IDLE);
  assign acc_in  = valid_i && ready_o;

  // line memory, {upper, middle} per column
  always_ff @(posedge clk_i) begin
    if (we) line_mem[wa] <= wd;
    rd_q <= line_mem[ra];
  end

  assign ra = c_q + CW'(step_q) - CW'(2);

  // line updates after all reads
  always_comb begin
    we = 1'b0;
    wa = c_q;
    wd = {lw_q[2][PixW-1:0], pix_q};
    if (state_q == F_WR) begin
      case (step_q)
        2'd0: begin
          we = (c_q >= CW'(2));
          wa = c_q - CW'(2);
          wd = {lw_q[0][PixW-1:0], p1_q};
        end
        2'd1: begin
          we = row_end_q && (c_q != '0);
          wa = c_q - CW'(1);
          wd = {lw_q[1][PixW-1:0], p0_q};
        end
        2'd2: begin
          we = row_end_q;
        end
        default: we = 1'b0;
      endcase
    end
  end

  // result slots
  assign win = {pix_q, p0_q, p1_q,
                lw_q[2][PixW-1:0], lw_q[1][PixW-1:0], lw_q[0][PixW-1:0],
                lw_q[2][2*PixW-1:PixW], lw_q[1][2*PixW-1:PixW], lw_q[0][2*PixW-1:PixW]};

  always_comb begin
    slot_done = 1'b0;
    slot_filt = 1'b0;
    slot_row  = r_q;
    slot_col  = c_q;
    slot_win  = {9{pix_q}};
    slot_last = 1'b1;
    case (step_q)
      2'd0: begin
        slot_filt = filt_q;
        slot_win  = filt_q ? win : {9{lw_q[1][PixW-1:0]}};
        slot_row  = r_q - 16'd1;
        slot_col  = c_q - CW'(1);
        slot_last = (act_q[3:1] == 3'd0);
      end
      2'd1: begin
        slot_win  = {9{lw_q[2][PixW-1:0]}};
        slot_row  = r_q - 16'd1;
        slot_last = (act_q[3:2] == 2'd0);
      end
      2'd2: begin
        slot_win  = {9{p0_q}};
        slot_col  = c_q - CW'(1);
        slot_last = !act_q[3];
      end
      default: slot_done = 1'b1;
    endcase
  end

  assign entry_o = {slot_filt, slot_last, slot_done, slot_row, slot_col, slot_win};
  assign push_o  = (state_q == F_EM) && act_q[step_q] && !full_i;
  assign adv     = !act_q[step_q] || !full_i;

  // item capture
  always_ff @(posedge clk_i) begin
    if (acc_in) begin
      pix_q     <= pix_i;
      p0_q      <= rec0_q;
      p1_q      <= rec1_q;
      r_q       <= row_q;
      c_q       <= col_q;
      row_end_q <= row_end;
      filt_q    <= filt;
      act_q     <= act;
    end
    if (state_q == F_RD && step_q != 2'd0) lw_q[step_q - 2'd1] <= rd_q;
  end

  // position, recent pixels and sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= F_IDLE;
      step_q  <= 2'd0;
      col_q   <= '0;
      row_q   <= '0;
      rec0_q  <= '0;
      rec1_q  <= '0;
    end else begin
      if (acc_in) begin
        rec1_q <= rec0_q;
        rec0_q <= pix_i;
        if (row_end) begin
          col_q <= '0;
          row_q <= last_row ? 16'd0 : row_q + 16'd1;
        end else begin
          col_q <= col_q + CW'(1);
        end
      end
      case (state_q)
        F_IDLE: begin
          if (acc_in) begin
            state_q <= F_RD;
            step_q  <= 2'd0;
          end
        end
        F_RD: begin
          if (step_q == 2'd3) begin
            state_q <= F_WR;
            step_q  <= 2'd0;
          end else begin
            step_q <= step_q + 2'd1;
          end
        end
        F_WR: begin
          if (step_q == 2'd2) begin
            state_q <= F_EM;
            step_q  <= 2'd0;
          end else begin
            step_q <= step_q + 2'd1;
          end
        end
        default: begin
          if (adv) begin
            if (step_q == 2'd3) state_q <= F_IDLE;
            step_q <= step_q + 2'd1;
          end
        end
      endcase
    end
  end

endmodule

// ===== hw/rtl/wf3_back.sv =====
module wf3_back import wf3_pkg::*; #(
  parameter int MAX_WIDTH = DefMaxWidth,
  parameter int CW        = $clog2(MAX_WIDTH),
  parameter int EW        = 3 + RowW + CW + 9 * PixW
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic [1:0]      mode_i,
  input  logic            empty_i,
  output logic            pop_o,
  input  logic [EW-1:0]   entry_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output logic [PixW-1:0] pix_o,
  output logic [RowW-1:0] row_o,
  output logic [CW-1:0]   col_o,
  output logic            last_o,
  output logic            done_o
);

  localparam int WinW = 9 * PixW;

  localparam logic [2:0] B_IDLE = 3'd0;
  localparam logic [2:0] B_CALC = 3'd1;
  localparam logic [2:0] B_ACC  = 3'd2;
  localparam logic [2:0] B_DIV  = 3'd3;
  localparam logic [2:0] B_OUT  = 3'd4;

  logic [2:0]        state_q;
  logic [3:0]        k_q;
  logic [2:0]        i_q;
  logic [EW-1:0]     ent_q;
  logic [PixW-1:0]   res_q, simple_res;
  logic [27:0]       acc_q  [3];
  logic [17:0]       wsum_q [3];
  logic [27:0]       prod   [3];
  logic [16:0]       wt     [3];
  logic [27:0]       trial  [3];
  logic [2:0]        ge;
  logic [WinW-1:0]   win;
  logic              filt;

  assign win    = ent_q[WinW-1:0];
  assign col_o  = ent_q[WinW +: CW];
  assign row_o  = ent_q[WinW+CW +: RowW];
  assign done_o = ent_q[WinW+CW+RowW];
  assign last_o = ent_q[WinW+CW+RowW+1];
  assign filt   = ent_q[WinW+CW+RowW+2];

  assign pix_o       = res_q;
  assign out_valid_o = (state_q == B_OUT);
  assign pop_o       = (state_q == B_IDLE) && !empty_i;

  // spatial distance of a window tap from the centre
  function automatic logic [1:0] tap_dist(input logic [3:0] k);
    logic [1:0] r;
    case (k)
      4'd4:                      r = 2'd0;
      4'd1, 4'd3, 4'd5, 4'd7:    r = 2'd1;
      default:                   r = 2'd2;
    endcase
    return r;
  endfunction

  // impulse, mean and sharpen for one channel
  function automatic logic [ChW-1:0] simple_ch(input logic [1:0] mode,
                                               input logic [9*ChW-1:0] w);
    logic [ChW-1:0]  v, n, r;
    logic [3:0]      far;
    logic [10:0]     s8;
    logic [11:0]     s9;
    logic [23:0]     m;
    logic [11:0]     lap;
    logic [9:0]      mag;
    logic [21:0]     mq;
    logic [11:0]     t;
    v   = w[4*ChW +: ChW];
    far = 4'd0;
    s8  = 11'd0;
    r   = v;
    for (int k = 0; k < 9; k++) begin
      n = w[k*ChW +: ChW];
      if (k != 4) begin
        s8 = s8 + 11'(n);
        if (((n > v) ? n - v : v - n) > 8'd16) far = far + 4'd1;
      end
    end
    s9  = 12'(s8) + 12'(v);
    // reciprocal of nine, exact for these ranges
    m   = s9 * 12'd3641;
    lap = 12'(w[1*ChW +: ChW]) + 12'(w[3*ChW +: ChW]) + 12'(w[5*ChW +: ChW])
        + 12'(w[7*ChW +: ChW]) - {2'b00, v, 2'b00};
    mag = lap[11] ? 10'(-lap) : 10'(lap);
    mq  = mag * 12'd3641;
    t   = lap[11] ? 12'(v) - 12'(mq[21:15]) : 12'(v) + 12'(mq[21:15]);
    case (mode)
      ModeImpulse: r = (far == 4'd8) ? s8[10:3] : v;
      ModeMean:    r = m[22:15];
      ModeSharpen: begin
        if (t[11]) r = 8'd0;
        else if (t > 12'd255) r = 8'd255;
        else r = t[7:0];
      end
      default:     r = v;
    endcase
    return r;
  endfunction

  always_comb begin
    for (int ch = 0; ch < 3; ch++) begin
      simple_res[ch*ChW +: ChW] = simple_ch(mode_i, {
        win[8*PixW+ch*ChW +: ChW], win[7*PixW+ch*ChW +: ChW], win[6*PixW+ch*ChW +: ChW],
        win[5*PixW+ch*ChW +: ChW], win[4*PixW+ch*ChW +: ChW], win[3*PixW+ch*ChW +: ChW],
        win[2*PixW+ch*ChW +: ChW], win[1*PixW+ch*ChW +: ChW], win[0*PixW+ch*ChW +: ChW]});
    end
  end

  // bilateral lanes: one tap per cycle, then one quotient bit per cycle
  always_comb begin
    for (int ch = 0; ch < 3; ch++) begin
      logic [ChW-1:0] n, v, d;
      n        = win[k_q*PixW + ch*ChW +: ChW];
      v        = win[4*PixW + ch*ChW +: ChW];
      d        = (n > v) ? n - v : v - n;
      wt[ch]   = exp_w(4'(tap_dist(k_q)) + sq_div(d));
      prod[ch] = 28'(wt[ch] * n);
      trial[ch] = 28'(wsum_q[ch]) << i_q;
      ge[ch]    = acc_q[ch] >= trial[ch];
    end
  end

  // entry hold and lane registers
  always_ff @(posedge clk_i) begin
    if (pop_o) ent_q <= entry_i;
    case (state_q)
      B_CALC: begin
        res_q <= filt ? simple_res : win[4*PixW +: PixW];
        for (int ch = 0; ch < 3; ch++) begin
          acc_q[ch]  <= '0;
          wsum_q[ch] <= '0;
        end
      end
      B_ACC: begin
        for (int ch = 0; ch < 3; ch++) begin
          acc_q[ch]  <= acc_q[ch] + prod[ch];
          wsum_q[ch] <= wsum_q[ch] + 18'(wt[ch]);
        end
      end
      B_DIV: begin
        for (int ch = 0; ch < 3; ch++) begin
          res_q[ch*ChW + 32'(i_q)] <= ge[ch];
          if (ge[ch]) acc_q[ch] <= acc_q[ch] - trial[ch];
        end
      end
      default: ;
    endcase
  end

  // sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= B_IDLE;
      k_q     <= 4'd0;
      i_q     <= 3'd0;
    end else begin
      case (state_q)
        B_IDLE: begin
          if (pop_o) state_q <= B_CALC;
        end
        B_CALC: begin
          k_q <= 4'd0;
          state_q <= (filt && mode_i == ModeBilateral) ? B_ACC : B_OUT;
        end
        B_ACC: begin
          if (k_q == 4'd8) begin
            state_q <= B_DIV;
            i_q     <= 3'd7;
          end else begin
            k_q <= k_q + 4'd1;
          end
        end
        B_DIV: begin
          if (i_q == 3'd0) state_q <= B_OUT;
          else i_q <= i_q - 3'd1;
        end
        B_OUT: begin
          if (out_ready_i) state_q <= B_IDLE;
        end
        default: state_q <= B_IDLE;
      endcase
    end
  end

endmodule
